// ===== rtl/bma_pkg.sv =====
// Shared constants, codes, command and status types for the buddy allocator.
// No dependencies; imported by every module of the block.
package bma_pkg;

  localparam int MAX_ORDER    = 10;
  localparam int MIN_SHIFT    = 4;   // smallest block is 16 bytes
  localparam int HEADER_BYTES = 16;
  localparam int SLOT_W       = MAX_ORDER;
  localparam int NSLOTS       = 1 << SLOT_W;
  localparam int LINK_W       = SLOT_W + 1;
  localparam int ORD_W        = 4;
  localparam int REQ_W        = 24;
  localparam int TOT_W        = REQ_W + 1;
  localparam int ADDR_W       = 14;
  localparam int STAT_W       = 2;
  localparam int HEAP_BYTES   = 1 << (SLOT_W + MIN_SHIFT);

  localparam logic [LINK_W-1:0] NONE = LINK_W'(NSLOTS);

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BIG    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd3;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd2;
  localparam logic [OP_W-1:0] OP_SRCH    = 4'd3;
  localparam logic [OP_W-1:0] OP_POP     = 4'd4;
  localparam logic [OP_W-1:0] OP_PRD_UP  = 4'd5;
  localparam logic [OP_W-1:0] OP_PRD_AT  = 4'd6;
  localparam logic [OP_W-1:0] OP_PWR     = 4'd7;
  localparam logic [OP_W-1:0] OP_PWR_DEC = 4'd8;
  localparam logic [OP_W-1:0] OP_PUSH1   = 4'd9;
  localparam logic [OP_W-1:0] OP_PUSH2   = 4'd10;
  localparam logic [OP_W-1:0] OP_ORD     = 4'd11;
  localparam logic [OP_W-1:0] OP_RDLINK  = 4'd12;
  localparam logic [OP_W-1:0] OP_REM     = 4'd13;
  localparam logic [OP_W-1:0] OP_ORDW    = 4'd14;
  localparam logic [OP_W-1:0] OP_FIN     = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              fin_ok;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic too_big;
    logic bad_free;
    logic ord_bad;
    logic head_none;
    logic o_at_max;
    logic o_gt_need;
    logic pair_set;
    logic clear_last;
  } sts_t;

  // A link at or above the slot count means an empty list.
  function automatic logic [LINK_W-1:0] clean(input logic [LINK_W-1:0] l);
    return l[SLOT_W] ? NONE : l;
  endfunction

  // Pair bit of the tree node of order p that contains slot s.
  function automatic logic [SLOT_W-1:0] pair_index(input logic [ORD_W-1:0] p,
                                                   input logic [SLOT_W-1:0] s);
    logic [LINK_W-1:0] base;
    logic [SLOT_W-1:0] sh;
    base = (LINK_W'(1) << (ORD_W'(MAX_ORDER) - p)) - LINK_W'(1);
    sh   = s >> p;
    return base[SLOT_W-1:0] + sh;
  endfunction

  // Number of significant bits of m.
  function automatic logic [ORD_W-1:0] bit_length(input logic [SLOT_W-1:0] m);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (m[i]) r = ORD_W'(i + 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/buddy_memory_allocator_unit.sv =====
// Top level of the buddy allocator: joins the sequencer and the datapath.
// Depends on bma_pkg, bma_ctrl and bma_dp.
//
//   channel | handshake             | word
//   in      | in_valid / in_stall   | action, request_bytes, release_address
//   out     | out_valid / out_stall | data_address, status
//
// An item is handled as a sequence of steps: a search step per order searched, split steps per
// split level, merge steps per merge level and the pair-bit and list updates; each step is
// bounded by one access per memory port. After reset a clearing pass over all 1024 slots
// initialises the link and pair-bit memories, and no word is taken meanwhile.
// A new word is taken while a result is still held, but the next result waits for it.
module buddy_memory_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [bma_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bma_pkg::ADDR_W-1:0]  release_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bma_pkg::ADDR_W-1:0]  data_address,
  output logic [bma_pkg::STAT_W-1:0]  status
);
  import bma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bma_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .data_address    (data_address),
    .status          (status)
  );

endmodule

// ===== rtl/bma_dp.sv =====
// Allocator datapath: free-list heads, link, order and pair-bit memories.
// Depends on bma_pkg; driven by commands from bma_ctrl.
module bma_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  bma_pkg::cmd_t                cmd,
  output bma_pkg::sts_t                sts,
  input  logic                         action,
  input  logic [bma_pkg::REQ_W-1:0]    request_bytes,
  input  logic [bma_pkg::ADDR_W-1:0]   release_address,
  output logic [bma_pkg::ADDR_W-1:0]   data_address,
  output logic [bma_pkg::STAT_W-1:0]   status
);
  import bma_pkg::*;

  logic [LINK_W-1:0] heads [0:MAX_ORDER];
  logic [LINK_W-1:0] next_mem [0:NSLOTS-1];
  logic [LINK_W-1:0] prev_mem [0:NSLOTS-1];
  logic [ORD_W-1:0]  ord_mem  [0:NSLOTS-1];
  logic              pair_mem [0:NSLOTS-1];

  logic [LINK_W-1:0] rd_next, rd_prev, h;
  logic [ORD_W-1:0]  rd_ord, o, need;
  logic              rd_pair, is_free, zero_req, too_big, bad_free;
  logic [SLOT_W-1:0] s, t, paddr, clr_idx;

  logic [LINK_W-1:0] cur_head, n_pop, p_rem, n_rem;
  logic [SLOT_W-1:0] bit_o, b, next_ra, pair_ra;
  logic [ORD_W-1:0]  o_up;
  logic [TOT_W-1:0]  total, total_c, total_m1;
  logic [ADDR_W-1:0] off;
  logic [SLOT_W+15:0] omask;

  assign cur_head = (o <= ORD_W'(MAX_ORDER)) ? heads[o] : NONE;
  assign bit_o    = SLOT_W'(1) << o;
  assign b        = s ^ bit_o;
  assign o_up     = o + ORD_W'(1);
  assign n_pop    = clean(rd_next);
  assign p_rem    = clean(rd_prev);
  assign n_rem    = clean(rd_next);
  assign next_ra  = (cmd.op == OP_RDLINK) ? b : s;
  assign pair_ra  = (cmd.op == OP_PRD_AT) ? pair_index(o, s) : pair_index(o_up, s);
  assign omask    = ({{(SLOT_W+15){1'b0}}, 1'b1} << o) - (SLOT_W+16)'(1);

  // Request size rule and the order that it needs.
  assign total    = {1'b0, request_bytes} + TOT_W'(HEADER_BYTES);
  assign total_c  = (total < TOT_W'(1 << MIN_SHIFT)) ? TOT_W'(1 << MIN_SHIFT) : total;
  assign total_m1 = (total_c - TOT_W'(1)) >> MIN_SHIFT;
  assign off      = release_address - ADDR_W'(HEADER_BYTES);

  assign sts.is_free    = is_free;
  assign sts.zero_req   = zero_req;
  assign sts.too_big    = too_big;
  assign sts.bad_free   = bad_free;
  assign sts.ord_bad    = (o > ORD_W'(MAX_ORDER)) || ((s & omask[SLOT_W-1:0]) != '0);
  assign sts.head_none  = cur_head[SLOT_W];
  assign sts.o_at_max   = (o == ORD_W'(MAX_ORDER));
  assign sts.o_gt_need  = (o > need);
  assign sts.pair_set   = rd_pair;
  assign sts.clear_last = (clr_idx == SLOT_W'(NSLOTS - 1));

  // Memories: one registered read per memory every cycle, writes by command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLEAR: begin
        next_mem[clr_idx] <= NONE;
        prev_mem[clr_idx] <= NONE;
        pair_mem[clr_idx] <= 1'b0;
      end
      OP_POP: begin
        if (!n_pop[SLOT_W]) prev_mem[n_pop[SLOT_W-1:0]] <= NONE;
      end
      OP_PWR, OP_PWR_DEC: begin
        pair_mem[paddr] <= ~rd_pair;
      end
      OP_PUSH1: begin
        next_mem[t] <= cur_head;
        prev_mem[t] <= NONE;
      end
      OP_PUSH2: begin
        if (!h[SLOT_W]) prev_mem[h[SLOT_W-1:0]] <= {1'b0, t};
      end
      OP_REM: begin
        if (!p_rem[SLOT_W]) next_mem[p_rem[SLOT_W-1:0]] <= n_rem;
        if (!n_rem[SLOT_W]) prev_mem[n_rem[SLOT_W-1:0]] <= p_rem;
        pair_mem[paddr] <= 1'b0;
      end
      OP_ORDW: begin
        ord_mem[s] <= need;
      end
      default: begin
      end
    endcase
    rd_next <= next_mem[next_ra];
    rd_prev <= prev_mem[b];
    rd_ord  <= ord_mem[s];
    rd_pair <= pair_mem[pair_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) heads[i] <= NONE;
      heads[MAX_ORDER] <= '0;
      clr_idx <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: clr_idx <= clr_idx + SLOT_W'(1);
        OP_POP:   heads[o] <= n_pop;
        OP_PUSH1: heads[o] <= {1'b0, t};
        OP_REM: begin
          if (p_rem[SLOT_W]) heads[o] <= n_rem;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_free  <= action;
        zero_req <= (request_bytes == '0);
        too_big  <= (total_c > TOT_W'(HEAP_BYTES));
        need     <= bit_length(total_m1[SLOT_W-1:0]);
        o        <= bit_length(total_m1[SLOT_W-1:0]);
        bad_free <= (release_address < ADDR_W'(HEADER_BYTES)) ||
                    (off[MIN_SHIFT-1:0] != '0);
        s        <= off[MIN_SHIFT +: SLOT_W];
        t        <= off[MIN_SHIFT +: SLOT_W];
      end
      OP_SRCH: begin
        if (cur_head[SLOT_W]) o <= o_up;
        else s <= cur_head[SLOT_W-1:0];
      end
      OP_ORD: o <= rd_ord;
      OP_PRD_UP, OP_PRD_AT: paddr <= pair_ra;
      OP_PWR_DEC: begin
        o <= o - ORD_W'(1);
        t <= s + (SLOT_W'(1) << (o - ORD_W'(1)));
      end
      OP_PUSH1: h <= cur_head;
      OP_REM: begin
        s <= s & ~bit_o;
        t <= s & ~bit_o;
        o <= o_up;
      end
      OP_FIN: begin
        if (cmd.fin_ok) begin
          data_address <= ADDR_W'({s, {MIN_SHIFT{1'b0}}}) + ADDR_W'(HEADER_BYTES);
          status       <= STAT_OK;
        end else begin
          data_address <= '0;
          status       <= cmd.code;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/bma_ctrl.sv =====
// Allocator sequencer: handshakes, clearing pass, search, split and merge steps.
// Depends on bma_pkg; commands bma_dp.
module bma_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bma_pkg::sts_t sts,
  output bma_pkg::cmd_t cmd
);
  import bma_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_ORD   = 5'd3;
  localparam logic [4:0] S_OCHK  = 5'd4;
  localparam logic [4:0] S_SRCH  = 5'd5;
  localparam logic [4:0] S_PRDN  = 5'd6;
  localparam logic [4:0] S_POP   = 5'd7;
  localparam logic [4:0] S_AUP   = 5'd8;
  localparam logic [4:0] S_AFLIP = 5'd9;
  localparam logic [4:0] S_SPLIT = 5'd10;
  localparam logic [4:0] S_SFLIP = 5'd11;
  localparam logic [4:0] S_PUSH1 = 5'd12;
  localparam logic [4:0] S_PUSH2 = 5'd13;
  localparam logic [4:0] S_MLOOP = 5'd14;
  localparam logic [4:0] S_MCHK  = 5'd15;
  localparam logic [4:0] S_REM   = 5'd16;
  localparam logic [4:0] S_FUP   = 5'd17;
  localparam logic [4:0] S_FFLIP = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  logic [4:0]        state, state_next;
  logic              out_valid_next, fin_ok, fin_ok_next, fire;
  logic [STAT_W-1:0] fin_code, fin_code_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    fin_ok_next   = fin_ok;
    fin_code_next = fin_code;
    fire          = 1'b0;
    cmd.op        = OP_NOP;
    cmd.fin_ok    = fin_ok;
    cmd.code      = fin_code;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        fin_ok_next   = 1'b0;
        fin_code_next = STAT_OK;
        if (sts.is_free) begin
          state_next = sts.bad_free ? S_FIN : S_ORD;
        end else if (sts.zero_req) begin
          fin_code_next = STAT_ZERO;
          state_next    = S_FIN;
        end else if (sts.too_big) begin
          fin_code_next = STAT_BIG;
          state_next    = S_FIN;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_ORD: begin
        cmd.op     = OP_ORD;
        state_next = S_OCHK;
      end
      S_OCHK: state_next = sts.ord_bad ? S_FIN : S_MLOOP;
      S_SRCH: begin
        cmd.op = OP_SRCH;
        if (!sts.head_none) begin
          state_next = S_PRDN;
        end else if (sts.o_at_max) begin
          fin_code_next = STAT_NOFREE;
          state_next    = S_FIN;
        end
      end
      S_PRDN: state_next = S_POP;
      S_POP: begin
        cmd.op     = OP_POP;
        state_next = S_AUP;
      end
      S_AUP: begin
        if (sts.o_at_max) begin
          state_next = S_SPLIT;
        end else begin
          cmd.op     = OP_PRD_UP;
          state_next = S_AFLIP;
        end
      end
      S_AFLIP: begin
        cmd.op     = OP_PWR;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.o_gt_need) begin
          cmd.op     = OP_PRD_AT;
          state_next = S_SFLIP;
        end else begin
          cmd.op      = OP_ORDW;
          fin_ok_next = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_SFLIP: begin
        cmd.op     = OP_PWR_DEC;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        cmd.op     = OP_PUSH1;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.op     = OP_PUSH2;
        state_next = sts.is_free ? S_FUP : S_SPLIT;
      end
      S_MLOOP: begin
        if (sts.o_at_max) begin
          state_next = S_PUSH1;
        end else begin
          cmd.op     = OP_PRD_UP;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.pair_set) begin
          cmd.op     = OP_RDLINK;
          state_next = S_REM;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_REM: begin
        cmd.op     = OP_REM;
        state_next = S_MLOOP;
      end
      S_FUP: begin
        if (sts.o_at_max) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_PRD_UP;
          state_next = S_FFLIP;
        end
      end
      S_FFLIP: begin
        cmd.op     = OP_PWR;
        state_next = S_FIN;
      end
      S_FIN: begin
        // The result register is rewritten only once the previous word has left.
        if (!out_valid || !out_stall) begin
          cmd.op     = OP_FIN;
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = (out_valid && out_stall) || fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fin_ok   <= fin_ok_next;
    fin_code <= fin_code_next;
  end

endmodule

// ===== dv/tb_buddy_memory_allocator_unit.sv =====
// Self-checking testbench for buddy_memory_allocator_unit: a bit-exact buddy heap predictor
// feeds a queue of expected words, which is checked against the result channel.
// Depends on bma_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_buddy_memory_allocator_unit;
  import bma_pkg::*;

  localparam int ACT_ALLOC = 0;
  localparam int ACT_FREE  = 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic              act;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] rel;
    logic [ADDR_W-1:0] want_addr;
    logic [STAT_W-1:0] want_stat;
    bit                drain;
  } heap_op_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] stat;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = 1'b0;
  logic [REQ_W-1:0]  request_bytes = '0;
  logic [ADDR_W-1:0] release_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] data_address;
  logic [STAT_W-1:0] status;

  buddy_memory_allocator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .request_bytes(request_bytes), .release_address(release_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_address(data_address), .status(status)
  );

  always #5 clk = ~clk;

  // Predicted heap state, kept in slot numbers with NSLOTS standing for an empty link.
  int unsigned       free_head [0:MAX_ORDER];
  logic [LINK_W-1:0] free_next [NSLOTS];
  logic [LINK_W-1:0] free_prev [NSLOTS];
  bit                pair_bit  [NSLOTS];
  logic [ORD_W-1:0]  block_ord [NSLOTS];
  bit                ever_granted [NSLOTS];

  heap_op_t    op_q[$];
  grant_t      grant_q[$];
  logic [ADDR_W-1:0] live_q[$];
  int          n_ok, n_fail, n_free, n_mismatch, cycles;

  function automatic int unsigned link_ok(int unsigned v);
    return (v < NSLOTS) ? v : NSLOTS;
  endfunction

  function automatic int unsigned node_of(int unsigned p, int unsigned s);
    return ((1 << (MAX_ORDER - p)) - 1) + ((s & (NSLOTS - 1)) >> p);
  endfunction

  function automatic void list_push(int unsigned o, int unsigned s);
    int unsigned h;
    h = link_ok(free_head[o]);
    free_next[s] = LINK_W'(h);
    free_prev[s] = LINK_W'(NSLOTS);
    if (h != NSLOTS) free_prev[h] = LINK_W'(s);
    free_head[o] = s;
  endfunction

  function automatic int unsigned list_pop(int unsigned o);
    int unsigned s, n;
    s = link_ok(free_head[o]);
    if (s == NSLOTS) return NSLOTS;
    n = link_ok(free_next[s]);
    free_head[o] = n;
    if (n != NSLOTS) free_prev[n] = LINK_W'(NSLOTS);
    return s;
  endfunction

  function automatic void list_unlink(int unsigned o, int unsigned s);
    int unsigned p, n;
    p = link_ok(free_prev[s]);
    n = link_ok(free_next[s]);
    if (p == NSLOTS) free_head[o] = n;
    else free_next[p] = LINK_W'(n);
    if (n != NSLOTS) free_prev[n] = LINK_W'(p);
  endfunction

  function automatic void heap_reset();
    for (int o = 0; o <= MAX_ORDER; o++) free_head[o] = NSLOTS;
    for (int i = 0; i < NSLOTS; i++) begin
      free_next[i] = '0;
      free_prev[i] = '0;
      pair_bit[i] = 1'b0;
      block_ord[i] = '0;
      ever_granted[i] = 1'b0;
    end
    list_push(MAX_ORDER, 0);
  endfunction

  // Works out the result word of one operation and updates the predicted heap.
  function automatic grant_t heap_apply(logic act, logic [REQ_W-1:0] req,
                                        logic [ADDR_W-1:0] rel);
    grant_t      g;
    int unsigned total, size, need, o, s, off;
    g.addr = '0;
    g.stat = STAT_OK;
    if (act == ACT_ALLOC) begin
      total = req + HEADER_BYTES;
      if (total < (1 << MIN_SHIFT)) total = 1 << MIN_SHIFT;
      if (req == 0) g.stat = STAT_ZERO;
      else if (total > HEAP_BYTES) g.stat = STAT_BIG;
      else begin
        size = 1 << MIN_SHIFT;
        need = 0;
        while (size < total && need < MAX_ORDER) begin
          size = size << 1;
          need++;
        end
        s = NSLOTS;
        for (o = need; o <= MAX_ORDER; o++) begin
          s = list_pop(o);
          if (s != NSLOTS) break;
        end
        if (s == NSLOTS) g.stat = STAT_NOFREE;
        else begin
          if (o < MAX_ORDER) pair_bit[node_of(o + 1, s)] ^= 1'b1;
          while (o > need) begin
            pair_bit[node_of(o, s)] ^= 1'b1;
            o--;
            list_push(o, (s + (1 << o)) & (NSLOTS - 1));
          end
          block_ord[s] = ORD_W'(need);
          ever_granted[s] = 1'b1;
          g.addr = ADDR_W'((s << MIN_SHIFT) + HEADER_BYTES);
        end
      end
    end else if (rel >= HEADER_BYTES) begin
      off = rel - HEADER_BYTES;
      s = off >> MIN_SHIFT;
      if ((off & ((1 << MIN_SHIFT) - 1)) == 0 && s < NSLOTS) begin
        o = block_ord[s];
        if (o <= MAX_ORDER && (s & ((1 << o) - 1)) == 0) begin
          while (o < MAX_ORDER && pair_bit[node_of(o + 1, s)]) begin
            list_unlink(o, s ^ (1 << o));
            s = s & ~(1 << o);
            pair_bit[node_of(o + 1, s)] ^= 1'b1;
            o++;
          end
          list_push(o, s);
          if (o < MAX_ORDER) pair_bit[node_of(o + 1, s)] ^= 1'b1;
        end
      end
    end
    return g;
  endfunction

  function automatic void add_op(logic act, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] rel,
                                 bit drain);
    heap_op_t w;
    grant_t   g;
    g = heap_apply(act, req, rel);
    w.act = act; w.req = req; w.rel = rel; w.drain = drain;
    w.want_addr = g.addr; w.want_stat = g.stat;
    if (act == ACT_ALLOC && g.stat == STAT_OK) live_q.push_back(g.addr);
    op_q.push_back(w);
  endfunction

  // Picks a slot that has been granted at some time, so its stored order is defined.
  function automatic logic [ADDR_W-1:0] granted_addr();
    int unsigned s;
    do s = $urandom_range(NSLOTS - 1); while (!ever_granted[s]);
    return ADDR_W'((s << MIN_SHIFT) + HEADER_BYTES);
  endfunction

  function automatic void add_random(bit drain);
    int unsigned r, k;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    if (live_q.size() == 0 || r < 52) begin
      r = $urandom_range(99);
      if (r < 65)      k = $urandom_range(1, 240);
      else if (r < 88) k = $urandom_range(241, 2000);
      else if (r < 94) k = $urandom_range(2001, HEAP_BYTES - HEADER_BYTES);
      else if (r < 97) k = 0;
      else             k = $urandom_range(32'hFFFFFF);
      add_op(ACT_ALLOC, REQ_W'(k), ADDR_W'($urandom), drain);
    end else begin
      r = $urandom_range(99);
      if (r < 82) begin
        k = $urandom_range(live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
      end else if (r < 88) a = '0;
      else if (r < 92) a = ADDR_W'($urandom_range(1, HEADER_BYTES - 1));
      else if (r < 99) a = ADDR_W'($urandom_range(HEADER_BYTES, 16383)) | ADDR_W'($urandom_range(1, 15));
      else a = granted_addr();
      if (a != '0 && r >= 82) begin
        // a freed live block must leave the live list too
        for (int i = 0; i < live_q.size(); i++)
          if (live_q[i] == a) begin live_q.delete(i); break; end
      end
      add_op(ACT_FREE, REQ_W'($urandom), a, drain);
    end
  endfunction

  // Sender: bursts of random length with random gaps.
  int unsigned burst_left = 1, gap_left = 0;
  heap_op_t    cur;
  int          words_sent;
  always @(posedge clk) begin
    bit load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        grant_q.push_back('{addr: cur.want_addr, stat: cur.want_stat});
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        load = 1'b0;
        if (gap_left > 0) gap_left--;
        else if (op_q.size() > 0 && !(op_q[0].drain && grant_q.size() > 0)) begin
          cur = op_q.pop_front();
          action <= cur.act;
          request_bytes <= cur.req;
          release_address <= cur.rel;
          load = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end
        in_valid <= load;
      end
    end
  end

  // Receiver: stall mode is picked anew at random whenever the stall counter wraps.
  int unsigned stall_mode, stall_cnt;
  always @(posedge clk) begin
    if (stall_cnt == 0) stall_mode = $urandom_range(3);
    stall_cnt = (stall_cnt + 1) % 128;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 30);
      2: out_stall <= ($urandom_range(99) < 80);
      default: out_stall <= (stall_cnt % 16) < 5;
    endcase
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result word: addr %0d status %0d", data_address, status);
      end else begin
        g = grant_q.pop_front();
        if (g.addr !== data_address || g.stat !== status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                     g.addr, g.stat, data_address, status);
        end else if (status == STAT_OK && g.addr != '0) n_ok++;
        else if (status != STAT_OK) n_fail++;
        else n_free++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", grant_q.size());
      $display("tb_buddy_memory_allocator_unit: done, errors");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] a;
    heap_reset();
    // Directed part: size edges, whole-heap grant, exhaustion, bad and null frees.
    add_op(ACT_ALLOC, 24'd0, '0, 0);
    add_op(ACT_ALLOC, 24'hFFFFFF, 14'h3FFF, 0);
    add_op(ACT_ALLOC, REQ_W'(HEAP_BYTES - HEADER_BYTES + 1), '0, 0);
    add_op(ACT_ALLOC, REQ_W'(HEAP_BYTES - HEADER_BYTES), '0, 0);
    add_op(ACT_ALLOC, 24'd1, '0, 0);
    a = live_q.pop_back();
    add_op(ACT_FREE, 24'hFFFFFF, a, 0);
    add_op(ACT_ALLOC, 24'd1, '0, 0);
    add_op(ACT_ALLOC, 24'd16, '0, 0);
    add_op(ACT_ALLOC, 24'd17, '0, 0);
    add_op(ACT_ALLOC, 24'd1000, '0, 0);
    add_op(ACT_ALLOC, REQ_W'(HEAP_BYTES / 2 - HEADER_BYTES), '0, 0);
    add_op(ACT_FREE, '0, '0, 0);
    add_op(ACT_FREE, '0, 14'd15, 0);
    add_op(ACT_FREE, '0, 14'h3FFF, 0);
    add_op(ACT_FREE, '0, live_q[0] + 14'd8, 0);
    for (int i = 0; i < 3; i++) begin
      a = live_q.pop_front();
      add_op(ACT_FREE, '0, a, 0);
    end
    // Freeing the same block twice is carried out with its stored order.
    add_op(ACT_FREE, '0, a, 0);
    while (live_q.size() > 0) add_op(ACT_FREE, '0, live_q.pop_front(), 0);
    add_op(ACT_ALLOC, REQ_W'(HEAP_BYTES - HEADER_BYTES), '0, 0);
    add_op(ACT_FREE, '0, live_q.pop_front(), 0);
    for (int i = 0; i < 700; i++) add_random(i == 350);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (op_q.size() > 0 || in_valid || grant_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words sent: %0d blocks granted, %0d refused, %0d frees checked",
             words_sent, n_ok, n_fail, n_free);
    if (n_mismatch == 0 && grant_q.size() == 0) begin
      $display("tb_buddy_memory_allocator_unit: done, clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb_buddy_memory_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule
